### rtl/lpr_pkg.sv
// lpr_pkg: shared types and constants for the LRU page replacement block.
// No dependencies. Used by lpr_cell and lru_page_replacement.
package lpr_pkg;

  localparam int CFG_W = 5;
  localparam int FAULT_W = 32;
  localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  // Broadcast control shared by every cell in the chain.
  typedef struct packed {
    logic upd;   // request beat accepted this cycle
    logic miss;  // no cell matched
    logic room;  // set below its frame limit, append on miss
  } lpr_ctrl_t;

endpackage

### rtl/lpr_cell.sv
// lpr_cell: one recency slot of the LRU chain (page, valid, match, shift).
// Depends on lpr_pkg.
module lpr_cell
  import lpr_pkg::*;
#(
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lpr_ctrl_t            ctrl,
  input  logic [PAGE_BITS-1:0] req_page,
  input  logic [PAGE_BITS-1:0] nbr_page,
  input  logic                 nbr_valid,
  input  logic                 prv_valid,
  input  logic                 shift_in,
  output logic                 shift_out,
  output logic                 match,
  output logic [PAGE_BITS-1:0] page,
  output logic                 valid
);

  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic                 valid_r, valid_nxt;
  logic                 append;

  assign match     = valid_r && (page_r == req_page);
  assign shift_out = valid_r && (match || shift_in);
  assign append    = ctrl.miss && ctrl.room && !valid_r && prv_valid;

  always_comb begin
    page_nxt  = page_r;
    valid_nxt = valid_r;
    if (ctrl.upd) begin
      if (shift_out) begin
        page_nxt = nbr_valid ? nbr_page : req_page;
      end else if (append) begin
        page_nxt  = req_page;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign page  = page_r;
  assign valid = valid_r;

endmodule

### rtl/lru_page_replacement.sv
// lru_page_replacement: LRU set of resident pages built as a chain of cells.
// Result beat registered in the cycle after the request beat; 1 beat/cycle unless
// out_ready stalls. All cells compare in parallel and the recency order shifts in
// the same cycle. Synchronous active-low reset empties the set, zeroes the fault
// count and sets frames_in_use to 16. Depends on lpr_pkg and lpr_cell.
module lru_page_replacement
  import lpr_pkg::*;
#(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PAGE_BITS-1:0] in_page,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic                 out_evicted_valid,
  output logic [PAGE_BITS-1:0] out_evicted_page,
  output logic [FAULT_W-1:0]   out_fault_total,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     cfg_frames_in_use
);

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FW    = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;

  logic [CFG_W-1:0]     frames_r;
  logic [FW-1:0]        frames_ext;
  logic [IDX_W-1:0]     lim_idx;
  logic [MAX_FRAMES-1:0] valid_vec, match_vec;
  logic [MAX_FRAMES:0]  shift_chain;
  logic [PAGE_BITS-1:0] page_vec [MAX_FRAMES];
  lpr_ctrl_t            ctrl;
  logic                 in_fire, hit, evict;

  logic                 out_valid_r;
  logic                 out_hit_r;
  logic                 out_ev_valid_r;
  logic [PAGE_BITS-1:0] out_ev_page_r;
  logic [FAULT_W-1:0]   fault_r, fault_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= FRAMES_RESET;
    end else if (cfg_valid) begin
      frames_r <= cfg_frames_in_use;
    end
  end

  // Clamp limit into 1..MAX_FRAMES, kept as index of the last allowed slot.
  assign frames_ext = FW'(frames_r);
  always_comb begin
    if (frames_ext == '0) begin
      lim_idx = '0;
    end else if (frames_ext > FW'(MAX_FRAMES)) begin
      lim_idx = IDX_W'(MAX_FRAMES - 1);
    end else begin
      lim_idx = IDX_W'(frames_ext - FW'(1));
    end
  end

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign hit      = |match_vec;
  assign evict    = !hit && !ctrl.room;

  assign ctrl.upd  = in_fire;
  assign ctrl.miss = !hit;
  assign ctrl.room = !valid_vec[lim_idx];

  assign shift_chain[0] = evict;

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    logic [PAGE_BITS-1:0] nbr_page;
    logic                 nbr_valid;
    logic                 prv_valid;
    if (i == MAX_FRAMES - 1) begin : g_last
      assign nbr_page  = in_page;
      assign nbr_valid = 1'b0;
    end else begin : g_mid
      assign nbr_page  = page_vec[i+1];
      assign nbr_valid = valid_vec[i+1];
    end
    if (i == 0) begin : g_first
      assign prv_valid = 1'b1;
    end else begin : g_rest
      assign prv_valid = valid_vec[i-1];
    end

    lpr_cell #(
      .PAGE_BITS(PAGE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .req_page (in_page),
      .nbr_page (nbr_page),
      .nbr_valid(nbr_valid),
      .prv_valid(prv_valid),
      .shift_in (shift_chain[i]),
      .shift_out(shift_chain[i+1]),
      .match    (match_vec[i]),
      .page     (page_vec[i]),
      .valid    (valid_vec[i])
    );
  end

  always_comb begin
    fault_nxt = fault_r;
    if (in_fire && !hit && fault_r != FAULT_MAX) begin
      fault_nxt = fault_r + FAULT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      fault_r     <= '0;
    end else begin
      fault_r <= fault_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_hit_r      <= hit;
      out_ev_valid_r <= evict;
      out_ev_page_r  <= evict ? page_vec[0] : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_total   = fault_r;

  // Resident slots form a prefix of the chain.
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("resident slots not a prefix");

  // A page is resident in at most one slot.
  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("page matched in more than one slot");

  // A hit never evicts.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_ev_valid_r))
    else $error("eviction reported on a hit");

  // Fault total only moves on a missing request beat.
  a_fault_step: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && !hit) |=> $stable(fault_r))
    else $error("fault total changed without a miss");

endmodule

### test/tb_lru_page_replacement.sv
// tb_lru_page_replacement: self-checking bench for the LRU page replacement block.
// Queue-fed request driver, randomly stalling result sink, scoreboard against an
// in-bench LRU predictor. Depends on lpr_pkg and lru_page_replacement.
module tb_lru_page_replacement
  import lpr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGE_W = 16;
  localparam int FRAME_CAP = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SQUEEZE_CYCLES = 300;

  typedef struct packed {
    logic hit;
    logic evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
    logic [FAULT_W-1:0] fault_total;
  } page_outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PAGE_W-1:0] in_page = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic out_evicted_valid;
  logic [PAGE_W-1:0] out_evicted_page;
  logic [FAULT_W-1:0] out_fault_total;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_frames_in_use = '0;

  logic [PAGE_W-1:0] page_q[$];
  page_outcome_t outcome_q[$];

  // predictor state: index 0 is the least recent page
  logic [PAGE_W-1:0] lru_order[$];
  logic [CFG_W-1:0] frames_cfg = FRAMES_RESET;
  logic [FAULT_W-1:0] fault_cnt = '0;

  logic send_idle_en = 1'b1;
  logic sink_idle_en = 1'b1;
  logic squeeze_req = 1'b0;
  logic squeeze_done = 1'b0;
  int unsigned send_wait = 0;
  int unsigned sink_wait = 0;
  int unsigned idle_cycles = 0;
  int unsigned errors = 0;
  int unsigned n_req = 0;
  int unsigned n_hits = 0;
  int unsigned n_evict = 0;
  int unsigned n_cfg = 0;

  lru_page_replacement #(
    .MAX_FRAMES(FRAME_CAP),
    .PAGE_BITS(PAGE_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_page(in_page),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_hit(out_hit),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_page(out_evicted_page),
    .out_fault_total(out_fault_total),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_frames_in_use(cfg_frames_in_use)
  );

  always #4 clk = ~clk;

  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_page(input logic [PAGE_W-1:0] pg);
    page_q.insert(page_q.size(), pg);
  endfunction

  function automatic page_outcome_t lru_access(input logic [PAGE_W-1:0] pg);
    page_outcome_t r;
    int idx;
    int lim;
    r = '0;
    idx = -1;
    lim = (frames_cfg == 0) ? 1 : (frames_cfg > FRAME_CAP) ? FRAME_CAP : int'(frames_cfg);
    foreach (lru_order[i]) begin
      if (lru_order[i] == pg) idx = i;
    end
    if (idx >= 0) begin
      r.hit = 1'b1;
      lru_order.delete(idx);
      lru_order.insert(lru_order.size(), pg);
    end else begin
      // a lowered limit keeps the set at its current size: one out, one in
      if (lru_order.size() >= lim) begin
        r.evicted_valid = 1'b1;
        r.evicted_page = lru_order.pop_front();
      end
      lru_order.insert(lru_order.size(), pg);
      if (fault_cnt != FAULT_MAX) fault_cnt++;
    end
    r.fault_total = fault_cnt;
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_wait != 0) begin
        in_valid <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (page_q.size() != 0) begin
        in_valid <= 1'b1;
        in_page <= page_q.pop_front();
        send_wait <= send_idle_en ? rand_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result sink
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_wait <= 0;
      squeeze_done <= 1'b0;
    end else if (squeeze_req && !squeeze_done) begin
      out_ready <= 1'b0;
      sink_wait <= SQUEEZE_CYCLES;
      squeeze_done <= 1'b1;
    end else if (sink_wait != 0) begin
      out_ready <= 1'b0;
      sink_wait <= sink_wait - 1;
    end else begin
      out_ready <= 1'b1;
      sink_wait <= sink_idle_en ? rand_gap() : 0;
    end
  end

  // scoreboard: check result beats, then predict accepted request beats
  always @(posedge clk) begin
    page_outcome_t exp_o;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          errors++;
        end else begin
          exp_o = outcome_q.pop_front();
          if (out_hit !== exp_o.hit) begin
            $display("%0t: hit expected %0d got %0d", $time, exp_o.hit, out_hit);
            errors++;
          end
          if (out_evicted_valid !== exp_o.evicted_valid) begin
            $display("%0t: evicted_valid expected %0d got %0d", $time,
                     exp_o.evicted_valid, out_evicted_valid);
            errors++;
          end
          if (out_evicted_page !== exp_o.evicted_page) begin
            $display("%0t: evicted_page expected %h got %h", $time,
                     exp_o.evicted_page, out_evicted_page);
            errors++;
          end
          if (out_fault_total !== exp_o.fault_total) begin
            $display("%0t: fault_total expected %0d got %0d", $time,
                     exp_o.fault_total, out_fault_total);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        frames_cfg = cfg_frames_in_use;
        n_cfg++;
      end
      if (in_valid && in_ready) begin
        exp_o = lru_access(in_page);
        outcome_q.insert(outcome_q.size(), exp_o);
        n_req++;
        if (exp_o.hit) n_hits++;
        if (exp_o.evicted_valid) n_evict++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no beat for %0d cycles", $time, idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic wait_drained();
    do @(posedge clk); while (page_q.size() != 0 || in_valid || outcome_q.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_frames_in_use <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [PAGE_W-1:0] pool[32];
    logic [CFG_W-1:0] ramp[9];
    int unsigned pool_n;
    int unsigned n_items;
    logic [CFG_W-1:0] lim_v;
    ramp = '{5'd1, 5'd3, 5'd6, 5'd10, 5'd15, 5'd31, 5'd17, 5'd16, 5'd4};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit, page extremes, a hit on the lowest page
    queue_page(16'h0000);
    queue_page(16'hFFFF);
    queue_page(16'h0000);
    wait_drained();

    // zero limit acts as one, with two pages already resident
    write_frames(5'd0);
    queue_page(16'h1234);
    queue_page(16'h0000);
    queue_page(16'hABCD);
    queue_page(16'hABCD);
    queue_page(16'h5555);
    queue_page(16'hAAAA);
    wait_drained();

    for (int p = 0; p < 12; p++) begin
      lim_v = (p < 9) ? ramp[p] : CFG_W'($urandom_range(0, 31));
      write_frames(lim_v);
      if (p == 5) begin
        // hold the sink while requests keep coming, so the input stalls
        send_idle_en <= 1'b0;
        sink_idle_en <= 1'b1;
        squeeze_req <= 1'b1;
        n_items = 260;
      end else begin
        send_idle_en <= ($urandom_range(0, 3) != 0);
        sink_idle_en <= ($urandom_range(0, 3) != 0);
        n_items = $urandom_range(110, 150);
      end
      pool_n = $urandom_range(2, 24);
      for (int i = 0; i < pool_n; i++) pool[i] = PAGE_W'($urandom_range(0, 65535));
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 99) < 80) queue_page(pool[$urandom_range(0, pool_n - 1)]);
        else queue_page(PAGE_W'($urandom_range(0, 65535)));
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (outcome_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, outcome_q.size());
      errors++;
    end
    $display("Covered %0d requests (%0d hits, %0d evictions) over %0d limit writes;",
             n_req, n_hits, n_evict, n_cfg);
    $display("limits 0..31 incl. lowering below resident count; %0d errors", errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
